### rtl/ihg_pkg.sv
// Shared types, constants and header byte selection for the IPv4 header generator.
package ihg_pkg;

  localparam int unsigned DefaultFifoDepth = 4;
  localparam int unsigned HdrBytes = 20;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [4:0] HdrLastIdx = 5'(HdrBytes - 1);

  // Item kinds.
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] CFG_HDR_WORD0 = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_HDR_WORD1 = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_HDR_WORD2 = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SRC_ADDR = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DST_ADDR = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_CSUM_EN = 3'd5;

  // One accepted item as it travels through the queue.
  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       last;
  } item_t;

  // Header configuration as seen by the serializer.
  typedef struct packed {
    logic [31:0] word0;
    logic [31:0] word1;
    logic [31:0] word2;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic        csum_en;
    logic [15:0] csum;
  } hdr_cfg_t;

  // Returns header byte idx (0 to 19), most significant byte of each word first.
  function automatic logic [7:0] hdr_byte(hdr_cfg_t cfg, logic [4:0] idx);
    logic [31:0] w2;
    logic [31:0] word;
    w2 = cfg.csum_en ? {cfg.word2[31:16], cfg.csum} : cfg.word2;
    unique case (idx[4:2])
      3'd0:    word = cfg.word0;
      3'd1:    word = cfg.word1;
      3'd2:    word = w2;
      3'd3:    word = cfg.src_addr;
      3'd4:    word = cfg.dst_addr;
      default: word = '0;
    endcase
    unique case (idx[1:0])
      2'd0:    return word[31:24];
      2'd1:    return word[23:16];
      2'd2:    return word[15:8];
      default: return word[7:0];
    endcase
  endfunction

endpackage

### rtl/ipv4_header_generator.sv
// Top level of the IPv4 header generator: front end, item queue and byte serializer.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_stall_o   kind_i, payload_byte_i, payload_last_i
//   out      output     out_valid_o / out_stall_i out_byte_o, run_last_o, packet_end_o
//   cfg      input      cfg_we_i (no wait)        cfg_index_i, cfg_data_i
//
// A payload item yields one output byte; a start item yields the 20 header bytes, set by the
// serializer's byte counter. Unless the output stalls, sustained rate is one byte per cycle.
// Reset clears the header words to zero, enables the checksum and empties the queue.
// The input stalls only when the item queue is full; the output register lets the
// serializer take the next item whenever the downstream side accepts the current byte.
// The checksum is recomputed through the partial-sum, sum and checksum registers after each write.
module ipv4_header_generator #(
  parameter int unsigned FifoDepth = ihg_pkg::DefaultFifoDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic [7:0]                    payload_byte_i,
  input  logic                          payload_last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    out_byte_o,
  output logic                          run_last_o,
  output logic                          packet_end_o,
  input  logic                          cfg_we_i,
  input  logic [ihg_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ihg_pkg::CfgDataW-1:0]  cfg_data_i
);

  // Items flow front end -> queue -> serializer; the header settings go straight across.
  logic              push;
  ihg_pkg::item_t    push_item;
  logic              full;
  logic              pop;
  logic              head_valid;
  ihg_pkg::item_t    head_item;
  ihg_pkg::hdr_cfg_t hdr_cfg;

  ihg_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .payload_byte_i (payload_byte_i),
    .payload_last_i (payload_last_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .full_i         (full),
    .push_o         (push),
    .push_item_o    (push_item),
    .cfg_o          (hdr_cfg)
  );

  // The queue lets a payload stream keep flowing while a header is still being serialized.
  ihg_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_item_i  (push_item),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_item_o  (head_item)
  );

  ihg_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (hdr_cfg),
    .head_valid_i (head_valid),
    .head_item_i  (head_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .run_last_o   (run_last_o),
    .packet_end_o (packet_end_o)
  );

endmodule

### rtl/ihg_front.sv
// Input front end: item acceptance, configuration registers and checksum pipeline.
module ihg_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic [7:0]                    payload_byte_i,
  input  logic                          payload_last_i,
  input  logic                          cfg_we_i,
  input  logic [ihg_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ihg_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          full_i,
  output logic                          push_o,
  output ihg_pkg::item_t                push_item_o,
  output ihg_pkg::hdr_cfg_t             cfg_o
);

  logic [31:0] word0_q, word1_q, word2_q, src_q, dst_q;
  logic        csum_en_q;
  logic [17:0] sum_a_q, sum_b_q, sum_c_q;
  logic [17:0] sum_a_d, sum_b_d, sum_c_d;
  logic [19:0] sum_q, sum_d;
  logic [16:0] fold1;
  logic [15:0] fold2;
  logic [15:0] csum_q, csum_d;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  // A start item carries no byte of its own; keep the byte anyway, the back end ignores it.
  always_comb begin
    push_item_o.kind = kind_i;
    push_item_o.data = payload_byte_i;
    push_item_o.last = payload_last_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word0_q   <= '0;
      word1_q   <= '0;
      word2_q   <= '0;
      src_q     <= '0;
      dst_q     <= '0;
      csum_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ihg_pkg::CFG_HDR_WORD0: word0_q   <= cfg_data_i;
        ihg_pkg::CFG_HDR_WORD1: word1_q   <= cfg_data_i;
        ihg_pkg::CFG_HDR_WORD2: word2_q   <= cfg_data_i;
        ihg_pkg::CFG_SRC_ADDR:  src_q     <= cfg_data_i;
        ihg_pkg::CFG_DST_ADDR:  dst_q     <= cfg_data_i;
        ihg_pkg::CFG_CSUM_EN:   csum_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Three-stage ones-complement sum of the nine header halfwords (checksum field as zero).
  always_comb begin
    sum_a_d = {2'b0, word0_q[31:16]} + {2'b0, word0_q[15:0]} + {2'b0, word1_q[31:16]};
    sum_b_d = {2'b0, word1_q[15:0]} + {2'b0, word2_q[31:16]} + {2'b0, src_q[31:16]};
    sum_c_d = {2'b0, src_q[15:0]} + {2'b0, dst_q[31:16]} + {2'b0, dst_q[15:0]};
    sum_d   = {2'b0, sum_a_q} + {2'b0, sum_b_q} + {2'b0, sum_c_q};
    // Two end-around folds suffice: the sum stays below 2^20.
    fold1   = {1'b0, sum_q[15:0]} + {13'b0, sum_q[19:16]};
    fold2   = fold1[15:0] + {15'b0, fold1[16]};
    csum_d  = ~fold2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_a_q <= '0;
      sum_b_q <= '0;
      sum_c_q <= '0;
      sum_q   <= '0;
      csum_q  <= 16'hffff;
    end else begin
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
      sum_c_q <= sum_c_d;
      sum_q   <= sum_d;
      csum_q  <= csum_d;
    end
  end

  always_comb begin
    cfg_o.word0    = word0_q;
    cfg_o.word1    = word1_q;
    cfg_o.word2    = word2_q;
    cfg_o.src_addr = src_q;
    cfg_o.dst_addr = dst_q;
    cfg_o.csum_en  = csum_en_q;
    cfg_o.csum     = csum_q;
  end

endmodule

### rtl/ihg_fifo.sv
// Small show-ahead queue between the front end and the serializer.
module ihg_fifo #(
  parameter int unsigned Depth = ihg_pkg::DefaultFifoDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ihg_pkg::item_t push_item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           head_valid_o,
  output ihg_pkg::item_t head_item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  ihg_pkg::item_t        mem_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       cnt_q, cnt_d;

  assign full_o       = (cnt_q == CntFull);
  assign head_valid_o = (cnt_q != '0);
  assign head_item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("ihg_fifo: push into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_valid_o |-> !pop_i)
    else $error("ihg_fifo: pop from an empty queue");
`endif

endmodule

### rtl/ihg_back.sv
// Serializer: turns queued items into header or payload bytes behind an output register.
module ihg_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ihg_pkg::hdr_cfg_t cfg_i,
  input  logic              head_valid_i,
  input  ihg_pkg::item_t    head_item_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        out_byte_o,
  output logic              run_last_o,
  output logic              packet_end_o
);

  logic       load;
  logic       is_start;
  logic       hdr_done;
  logic [4:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;
  logic       run_last_q, run_last_d;
  logic       end_q, end_d;

  assign is_start = (head_item_i.kind == ihg_pkg::KIND_START);
  assign hdr_done = (idx_q == ihg_pkg::HdrLastIdx);
  assign load     = head_valid_i && (!valid_q || !out_stall_i);
  assign pop_o    = load && (!is_start || hdr_done);

  always_comb begin
    idx_d      = idx_q;
    valid_d    = valid_q;
    byte_d     = byte_q;
    run_last_d = run_last_q;
    end_d      = end_q;
    if (load) begin
      valid_d = 1'b1;
      if (is_start) begin
        byte_d     = ihg_pkg::hdr_byte(cfg_i, idx_q);
        run_last_d = hdr_done;
        end_d      = hdr_done && head_item_i.last;
        idx_d      = hdr_done ? '0 : idx_q + 1'b1;
      end else begin
        byte_d     = head_item_i.data;
        run_last_d = 1'b1;
        end_d      = head_item_i.last;
      end
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    run_last_q <= run_last_d;
    end_q      <= end_d;
  end

  assign out_valid_o  = valid_q;
  assign out_byte_o   = byte_q;
  assign run_last_o   = run_last_q;
  assign packet_end_o = end_q;

`ifndef SYNTHESIS
  a_idx_only_in_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != '0) |-> (head_valid_i && is_start))
    else $error("ihg_back: header index moved without a start item at the head");

  a_end_implies_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && end_q) |-> run_last_q)
    else $error("ihg_back: packet end without last byte of the item");

  a_header_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && is_start && hdr_done) |=> (idx_q == '0))
    else $error("ihg_back: header index did not wrap after the last header byte");
`endif

endmodule

### verif/tb_ipv4_header_generator.sv
// Self-checking testbench for the IPv4 header generator.
`timescale 1ns / 100ps

typedef struct packed {
  logic [7:0] data;
  logic       run_last;
  logic       pkt_end;
} wire_byte_t;

// Keeps its own copy of the header registers and the bytes that the block still owes.
class packet_byte_tracker;
  logic [31:0] word0;
  logic [31:0] word1;
  logic [31:0] word2;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic        csum_en;
  wire_byte_t  owed_bytes[$];
  int unsigned mismatches;
  int unsigned headers_seen;
  int unsigned payload_seen;
  int unsigned bytes_checked;

  function new();
    word0 = '0;
    word1 = '0;
    word2 = '0;
    src_addr = '0;
    dst_addr = '0;
    csum_en = 1'b1;
    mismatches = 0;
    headers_seen = 0;
    payload_seen = 0;
    bytes_checked = 0;
  endfunction

  function void apply_write(logic [ihg_pkg::CfgIdxW-1:0] idx, logic [31:0] data);
    case (idx)
      ihg_pkg::CFG_HDR_WORD0: word0 = data;
      ihg_pkg::CFG_HDR_WORD1: word1 = data;
      ihg_pkg::CFG_HDR_WORD2: word2 = data;
      ihg_pkg::CFG_SRC_ADDR:  src_addr = data;
      ihg_pkg::CFG_DST_ADDR:  dst_addr = data;
      ihg_pkg::CFG_CSUM_EN:   csum_en = data[0];
      default: ;
    endcase
  endfunction

  // Ones-complement sum of the nine header halves that are not the checksum itself.
  function logic [15:0] header_checksum();
    logic [31:0] acc;
    acc = 32'(word0[31:16]) + 32'(word0[15:0]) + 32'(word1[31:16]) + 32'(word1[15:0])
        + 32'(word2[31:16]) + 32'(src_addr[31:16]) + 32'(src_addr[15:0])
        + 32'(dst_addr[31:16]) + 32'(dst_addr[15:0]);
    while (acc[31:16] != 16'd0) begin
      acc = 32'(acc[15:0]) + 32'(acc[31:16]);
    end
    return ~acc[15:0];
  endfunction

  function void note_item(logic kind, logic [7:0] data, logic last);
    logic [31:0]  w2;
    logic [159:0] hdr;
    wire_byte_t   b;
    if (kind == ihg_pkg::KIND_PAYLOAD) begin
      b.data = data;
      b.run_last = 1'b1;
      b.pkt_end = last;
      owed_bytes.push_back(b);
      payload_seen++;
    end else begin
      w2 = csum_en ? {word2[31:16], header_checksum()} : word2;
      hdr = {word0, word1, w2, src_addr, dst_addr};
      for (int i = 0; i < ihg_pkg::HdrBytes; i++) begin
        b.data = hdr[159 - 8 * i -: 8];
        b.run_last = (i == ihg_pkg::HdrBytes - 1);
        b.pkt_end = (i == ihg_pkg::HdrBytes - 1) && last;
        owed_bytes.push_back(b);
      end
      headers_seen++;
    end
  endfunction

  function void check_byte(logic [7:0] data, logic run_last, logic pkt_end);
    wire_byte_t want;
    if (owed_bytes.size() == 0) begin
      $error("output byte 0x%02h arrived with nothing expected", data);
      mismatches++;
      return;
    end
    want = owed_bytes.pop_front();
    bytes_checked++;
    if (data !== want.data) begin
      $error("out_byte: expected 0x%02h, got 0x%02h", want.data, data);
      mismatches++;
    end
    if (run_last !== want.run_last) begin
      $error("run_last: expected %0b, got %0b", want.run_last, run_last);
      mismatches++;
    end
    if (pkt_end !== want.pkt_end) begin
      $error("packet_end: expected %0b, got %0b", want.pkt_end, pkt_end);
      mismatches++;
    end
  endfunction

  function int unsigned owed_count();
    return owed_bytes.size();
  endfunction
endclass

module tb_ipv4_header_generator;

  // Indexes past the last register; writes there must leave every register alone.
  localparam logic [ihg_pkg::CfgIdxW-1:0] CFG_UNUSED6 = 3'd6;
  localparam logic [ihg_pkg::CfgIdxW-1:0] CFG_UNUSED7 = 3'd7;

  // Queue depth plus output register plus the checksum pipeline, with margin.
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned DRAIN_LIMIT = 20000;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned SEGMENT_ITEMS = 36;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  logic                         kind_i = ihg_pkg::KIND_START;
  logic [7:0]                   payload_byte_i = '0;
  logic                         payload_last_i = 1'b0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [7:0]                   out_byte_o;
  logic                         run_last_o;
  logic                         packet_end_o;
  logic                         cfg_we_i = 1'b0;
  logic [ihg_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [ihg_pkg::CfgDataW-1:0] cfg_data_i = '0;

  // Idle percentages for the two sides; the receiver also takes one long hold-off on request.
  int unsigned         tx_idle_pct = 24;
  int unsigned         rx_stall_pct = 60;
  logic                rx_hold_req = 1'b0;
  int unsigned         settings_used = 0;

  packet_byte_tracker  tracker;

  ipv4_header_generator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .payload_byte_i (payload_byte_i),
    .payload_last_i (payload_last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .run_last_o     (run_last_o),
    .packet_end_o   (packet_end_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Ends the test as failed well past the slowest legal finish if the block hangs.
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  // Offers one item, possibly after random idle cycles, and holds it until the block takes it.
  // The item is handed to the tracker at the edge where it is accepted.
  task automatic send_item(input logic kind, input logic [7:0] data, input logic last);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    payload_byte_i <= data;
    payload_last_i <= last;
    do begin
      @(posedge clk_i);
    end while (in_stall_o !== 1'b0);
    tracker.note_item(kind, data, last);
  endtask

  // Waits until every owed byte has come out, with a limit, then lets the pipeline settle.
  task automatic drain_outputs();
    int unsigned waited;
    waited = 0;
    while (tracker.owed_count() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One register write; the write enable stays high so back-to-back writes need no gap.
  task automatic write_reg(input logic [ihg_pkg::CfgIdxW-1:0] idx, input logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    tracker.apply_write(idx, data);
  endtask

  // Reprograms every header register while the block is idle. The checksum enable gets the
  // full 32-bit value so that only bit 0 should matter. Optionally pokes the unused indexes.
  task automatic load_header(input logic [31:0] w0, input logic [31:0] w1,
                             input logic [31:0] w2, input logic [31:0] src,
                             input logic [31:0] dst, input logic [31:0] en_data,
                             input bit poke_unused);
    in_valid_i <= 1'b0;
    drain_outputs();
    write_reg(ihg_pkg::CFG_HDR_WORD0, w0);
    write_reg(ihg_pkg::CFG_HDR_WORD1, w1);
    write_reg(ihg_pkg::CFG_HDR_WORD2, w2);
    write_reg(ihg_pkg::CFG_SRC_ADDR, src);
    write_reg(ihg_pkg::CFG_DST_ADDR, dst);
    write_reg(ihg_pkg::CFG_CSUM_EN, en_data);
    if (poke_unused) begin
      write_reg(CFG_UNUSED6, $urandom);
      write_reg(CFG_UNUSED7, 32'hffff_ffff);
    end
    cfg_we_i <= 1'b0;
    settings_used++;
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Extremes turn up often so the end-around carry and the all-zero header both get exercised.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic load_random_header();
    load_header(pick_word(), pick_word(), pick_word(), pick_word(), pick_word(), $urandom,
                1'($urandom_range(0, 1)));
  endtask

  // Mostly well-formed packets (a start item and a short payload ending in a last flag),
  // with stray payload items and starts that never get their payload mixed in.
  task automatic send_random_traffic(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 16) : $urandom_range(0, 4);
        send_item(ihg_pkg::KIND_START, 8'($urandom), len == 0);
        for (int k = 0; k < int'(len); k++) begin
          send_item(ihg_pkg::KIND_PAYLOAD, 8'($urandom), k == int'(len) - 1);
        end
        sent += len + 1;
      end else if (pick < 9) begin
        send_item(ihg_pkg::KIND_PAYLOAD, 8'($urandom), 1'($urandom));
        sent++;
      end else begin
        send_item(ihg_pkg::KIND_START, 8'($urandom), 1'b0);
        sent++;
      end
    end
  endtask

  // Receiver: checks every accepted byte and picks the stall for the next cycle. A request
  // from the main sequence turns into one long hold-off that this process counts down.
  initial begin : receiver
    int unsigned hold_left;
    bit          hold_used;
    hold_left = 0;
    hold_used = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        tracker.check_byte(out_byte_o, run_last_o, packet_end_o);
      end
      if (rx_hold_req && !hold_used) begin
        hold_left = HOLD_CYCLES;
        hold_used = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < rx_stall_pct);
      end
    end
  end

  // Main sequence: reset, a directed part, then three random phases with different idling.
  initial begin
    tracker = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    // Header straight out of reset: all zero words, so the computed checksum is all ones.
    // The byte on a start item is junk and must not show up anywhere.
    send_item(ihg_pkg::KIND_START, 8'hff, 1'b1);

    // All-ones header: every addition carries. Payload bytes at both extremes follow.
    load_header(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                32'hffff_ffff, 1'b0);
    send_item(ihg_pkg::KIND_START, 8'h00, 1'b0);
    send_item(ihg_pkg::KIND_PAYLOAD, 8'h00, 1'b0);
    send_item(ihg_pkg::KIND_PAYLOAD, 8'hff, 1'b1);

    // Payload items with no start in front are passed through as they are.
    send_item(ihg_pkg::KIND_PAYLOAD, 8'ha5, 1'b0);
    send_item(ihg_pkg::KIND_PAYLOAD, 8'h5a, 1'b1);

    // Manual checksum: enable data has bit 0 clear but all other bits set. The writes to the
    // unused indexes must change nothing.
    load_header(32'h4500_0054, 32'h1c46_4000, 32'h4006_beef, 32'hc0a8_0001, 32'hc0a8_00c7,
                32'hffff_fffe, 1'b1);
    send_item(ihg_pkg::KIND_START, 8'h12, 1'b1);
    send_item(ihg_pkg::KIND_START, 8'h34, 1'b0);
    send_item(ihg_pkg::KIND_PAYLOAD, 8'h3c, 1'b1);

    // Checksum enabled while word 2 still carries a manual value in its low half: that half
    // is left out of the sum and replaced on the wire.
    load_header(32'h4500_0054, 32'h1c46_4000, 32'h4006_dead, 32'hc0a8_0001, 32'hc0a8_00c7,
                32'h0000_0001, 1'b0);
    send_item(ihg_pkg::KIND_START, 8'h00, 1'b0);
    send_item(ihg_pkg::KIND_PAYLOAD, 8'h80, 1'b0);
    send_item(ihg_pkg::KIND_PAYLOAD, 8'h01, 1'b1);

    // All-zero header with the manual checksum at its maximum.
    load_header(32'h0, 32'h0, 32'h0000_ffff, 32'h0, 32'h0, 32'h0, 1'b0);
    send_item(ihg_pkg::KIND_START, 8'h00, 1'b1);

    // Phase one: sender idles a little, receiver a lot.
    tx_idle_pct = 24;
    rx_stall_pct = 60;
    repeat (2) begin
      load_random_header();
      send_random_traffic(SEGMENT_ITEMS);
    end

    // Phase two: the other way round.
    tx_idle_pct = 60;
    rx_stall_pct = 24;
    repeat (2) begin
      load_random_header();
      send_random_traffic(SEGMENT_ITEMS);
    end

    // Phase three: no idling on either side. The receiver holds off for a long stretch at
    // the start while items keep coming, so the queue fills and the input stalls.
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    load_random_header();
    rx_hold_req <= 1'b1;
    send_random_traffic(SEGMENT_ITEMS);
    load_random_header();
    send_random_traffic(SEGMENT_ITEMS);

    in_valid_i <= 1'b0;
    drain_outputs();
    if (tracker.owed_count() != 0) begin
      $error("%0d expected output bytes never arrived", tracker.owed_count());
    end

    $display("Covered %0d header items and %0d payload items under %0d register settings,",
             tracker.headers_seen, tracker.payload_seen, settings_used + 1);
    $display("with %0d output bytes compared and one long receiver hold-off.",
             tracker.bytes_checked);
    if (tracker.mismatches == 0 && tracker.owed_count() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
